// ----- hdl/tcw_pkg.sv -----
// Shared types, codes and constants for the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

  // Default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Fixed payload widths
  localparam int KIND_W     = 2;
  localparam int CHAR_W     = 8;
  localparam int CELL_COL_W = 7;
  localparam int CELL_ROW_W = 5;
  localparam int CUR_COL_W  = 7;
  localparam int CUR_ROW_W  = 5;
  localparam int CUR_LIN_W  = 11;
  localparam int ATTR_W     = 8;
  localparam int CELL_W     = 16;

  // Queued cursor fields are sized for the largest screen (128 x 64)
  localparam int QCOL_W = 7;
  localparam int QROW_W = 6;

  localparam int QUEUE_DEPTH = 2;

  // Input kind codes
  localparam logic [KIND_W-1:0] KIND_PUT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SET  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

  // Characters and reset values
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;
  localparam logic [CELL_W-1:0] CELL_RESET   = 16'h8F00;
  localparam logic [ATTR_W-1:0] COLOR_RESET  = 8'h80;

  typedef enum logic [2:0] {
    OP_PUT,
    OP_BACKSPACE,
    OP_NEWLINE,
    OP_SET,
    OP_READ,
    OP_NONE
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ_WAIT,
    S_BLANK
  } back_state_t;

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] ch;
    logic [QCOL_W-1:0] col;
    logic [QROW_W-1:0] row;
  } cmd_t;

  // Front to queue
  typedef struct packed {
    logic push;
    cmd_t cmd;
  } q_wr_t;

  // Queue to back
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_rd_t;

endpackage

// ----- hdl/tcw_if.sv -----
// Valid/ready channel interfaces for console commands and results.
`timescale 1ns / 1ps

interface tcw_in_if import tcw_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [KIND_W-1:0]     kind;
  logic [CHAR_W-1:0]     char_code;
  logic [CELL_COL_W-1:0] cell_col;
  logic [CELL_ROW_W-1:0] cell_row;

  modport source (output valid, kind, char_code, cell_col, cell_row, input ready);
  modport sink (input valid, kind, char_code, cell_col, cell_row, output ready);
endinterface

interface tcw_out_if import tcw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CUR_COL_W-1:0] cursor_col;
  logic [CUR_ROW_W-1:0] cursor_row;
  logic [CUR_LIN_W-1:0] cursor_linear;
  logic [CHAR_W-1:0]    read_char;
  logic [ATTR_W-1:0]    read_attr;

  modport source (output valid, cursor_col, cursor_row, cursor_linear, read_char, read_attr,
                  input ready);
  modport sink (input valid, cursor_col, cursor_row, cursor_linear, read_char, read_attr,
                output ready);
endinterface

// ----- hdl/tcw_front.sv -----
// Front end: accepts command items and classifies them into queue entries.
`timescale 1ns / 1ps

module tcw_front import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  tcw_in_if.sink cmd,
  input  logic   busy,
  input  logic   q_full,
  output q_wr_t  q_wr
);

  logic              col_ok;
  logic              row_ok;
  logic [QCOL_W-1:0] col_sat;
  logic [QROW_W-1:0] row_sat;

  assign cmd.ready = !q_full && !busy;

  assign col_ok  = 32'(cmd.cell_col) < COLUMNS;
  assign row_ok  = 32'(cmd.cell_row) < ROWS;
  assign col_sat = col_ok ? cmd.cell_col : QCOL_W'(COLUMNS - 1);
  assign row_sat = row_ok ? QROW_W'(cmd.cell_row) : QROW_W'(ROWS - 1);

  always_comb begin
    q_wr.push    = cmd.valid && cmd.ready;
    q_wr.cmd.ch  = cmd.char_code;
    q_wr.cmd.col = col_sat;
    q_wr.cmd.row = row_sat;
    case (cmd.kind)
      KIND_PUT: begin
        if (cmd.char_code == CH_BACKSPACE) begin
          q_wr.cmd.op = OP_BACKSPACE;
        end else if (cmd.char_code == CH_NEWLINE) begin
          q_wr.cmd.op = OP_NEWLINE;
        end else begin
          q_wr.cmd.op = OP_PUT;
        end
      end
      KIND_SET: begin
        q_wr.cmd.op = OP_SET;
      end
      KIND_READ: begin
        // off-screen reads return zeros without touching the screen
        q_wr.cmd.op = (col_ok && row_ok) ? OP_READ : OP_NONE;
      end
      default: begin
        q_wr.cmd.op = OP_NONE;
      end
    endcase
  end

endmodule

// ----- hdl/tcw_fifo.sv -----
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module tcw_fifo import tcw_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  q_wr_t q_wr,
  input  logic  pop,
  output logic  full,
  output q_rd_t q_rd
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full       = count == CNT_W'(QUEUE_DEPTH);
  assign q_rd.valid = count != '0;
  assign q_rd.cmd   = slots[rd_ptr];
  assign do_pop     = pop && q_rd.valid;

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      slots[wr_ptr] <= q_wr.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_wr.push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (q_wr.push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !q_wr.push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/tcw_back.sv -----
// Back end: screen memory, cursor, scroll and clear sequencing, result register.
`timescale 1ns / 1ps

module tcw_back import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [ATTR_W-1:0] text_color,
  input  q_rd_t             q_rd,
  output logic              q_pop,
  output logic              busy,
  tcw_out_if.source         rsp
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int PROW_W = ROW_W + 1;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int LIN_W  = (ADDR_W > CUR_LIN_W) ? ADDR_W : CUR_LIN_W;

  logic [CELL_W-1:0] mem [CELLS];

  back_state_t state, state_next;
  logic [COL_W-1:0]  col, col_next;
  logic [ROW_W-1:0]  row, row_next;
  logic [ROW_W-1:0]  top, top_next;      // physical row shown as row 0
  logic [ADDR_W-1:0] clr_addr, clr_addr_next;
  logic [COL_W-1:0]  blank_x, blank_x_next;
  logic [ADDR_W-1:0] blank_base, blank_base_next;

  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [CELL_W-1:0] wr_data, rd_data;

  logic [ATTR_W-1:0] attr;
  logic              slot_free;
  logic              load_out;
  logic              do_nl;
  logic [COL_W-1:0]  bs_col;
  logic [COL_W-1:0]  ld_col;
  logic [ROW_W-1:0]  ld_row;
  logic [CHAR_W-1:0] ld_char;
  logic [ATTR_W-1:0] ld_attr;
  logic [LIN_W-1:0]  ld_lin;
  logic              out_valid;

  assign attr      = text_color | {text_color[3:0], 4'b0000};
  assign slot_free = !out_valid || rsp.ready;
  assign busy      = state == S_CLEAR;
  assign bs_col    = (col == '0) ? '0 : col - 1'b1;

  // Logical cell to memory address through the scroll offset
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c,
                                                   input logic [ROW_W-1:0] t);
    logic [PROW_W-1:0] p;
    p = {1'b0, r} + {1'b0, t};
    if (p >= PROW_W'(ROWS)) begin
      p = p - PROW_W'(ROWS);
    end
    return ADDR_W'(p[ROW_W-1:0]) * ADDR_W'(COLUMNS) + ADDR_W'(c);
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      col        <= '0;
      row        <= '0;
      top        <= '0;
      clr_addr   <= '0;
      blank_x    <= '0;
      blank_base <= '0;
    end else begin
      state      <= state_next;
      col        <= col_next;
      row        <= row_next;
      top        <= top_next;
      clr_addr   <= clr_addr_next;
      blank_x    <= blank_x_next;
      blank_base <= blank_base_next;
    end
  end

  always_comb begin
    state_next      = state;
    col_next        = col;
    row_next        = row;
    top_next        = top;
    clr_addr_next   = clr_addr;
    blank_x_next    = blank_x;
    blank_base_next = blank_base;
    q_pop           = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = cell_addr(row, col, top);
    wr_data         = {attr, CH_SPACE};
    rd_en           = 1'b0;
    rd_addr         = cell_addr(ROW_W'(q_rd.cmd.row), COL_W'(q_rd.cmd.col), top);
    load_out        = 1'b0;
    do_nl           = 1'b0;
    ld_char         = CH_NUL;
    ld_attr         = '0;

    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = CELL_RESET;
        if (clr_addr == ADDR_W'(CELLS - 1)) begin
          state_next = S_IDLE;
        end else begin
          clr_addr_next = clr_addr + 1'b1;
        end
      end
      S_IDLE: begin
        if (q_rd.valid && slot_free) begin
          q_pop    = 1'b1;
          load_out = 1'b1;
          case (q_rd.cmd.op)
            OP_PUT: begin
              wr_en   = 1'b1;
              wr_data = {attr, q_rd.cmd.ch};
              if (col == COL_W'(COLUMNS - 1)) begin
                do_nl = 1'b1;
              end else begin
                col_next = col + 1'b1;
              end
            end
            OP_BACKSPACE: begin
              wr_en    = 1'b1;
              wr_addr  = cell_addr(row, bs_col, top);
              col_next = bs_col;
            end
            OP_NEWLINE: begin
              do_nl = 1'b1;
            end
            OP_SET: begin
              col_next = COL_W'(q_rd.cmd.col);
              row_next = ROW_W'(q_rd.cmd.row);
            end
            OP_READ: begin
              rd_en      = 1'b1;
              load_out   = 1'b0;
              state_next = S_READ_WAIT;
            end
            default: begin
            end
          endcase
          if (do_nl) begin
            col_next = '0;
            if (row == ROW_W'(ROWS - 1)) begin
              // scroll: old top row becomes the new bottom row, blanked below
              top_next        = (top == ROW_W'(ROWS - 1)) ? '0 : top + 1'b1;
              blank_base_next = ADDR_W'(top) * ADDR_W'(COLUMNS);
              blank_x_next    = '0;
              state_next      = S_BLANK;
            end else begin
              row_next = row + 1'b1;
            end
          end
        end
      end
      S_READ_WAIT: begin
        load_out   = 1'b1;
        ld_char    = rd_data[CHAR_W-1:0];
        ld_attr    = rd_data[CELL_W-1:CHAR_W];
        state_next = S_IDLE;
      end
      S_BLANK: begin
        wr_en   = 1'b1;
        wr_addr = blank_base + ADDR_W'(blank_x);
        if (blank_x == COL_W'(COLUMNS - 1)) begin
          state_next = S_IDLE;
        end else begin
          blank_x_next = blank_x + 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign ld_col = col_next;
  assign ld_row = row_next;
  assign ld_lin = LIN_W'(ld_row) * LIN_W'(COLUMNS) + LIN_W'(ld_col);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.cursor_col    <= CUR_COL_W'(ld_col);
      rsp.cursor_row    <= CUR_ROW_W'(ld_row);
      rsp.cursor_linear <= ld_lin[CUR_LIN_W-1:0];
      rsp.read_char     <= ld_char;
      rsp.read_attr     <= ld_attr;
    end
  end

  assign rsp.valid = out_valid;

`ifndef NO_ASSERTIONS
  a_read_wait_follows_read: assert property (@(posedge clk) disable iff (rst)
    state == S_READ_WAIT |-> $past(rd_en))
    else $error("read wait without a preceding memory read");

  a_cursor_on_screen: assert property (@(posedge clk) disable iff (rst)
    32'(col) < COLUMNS && 32'(row) < ROWS)
    else $error("cursor off screen");

  a_top_in_range: assert property (@(posedge clk) disable iff (rst)
    32'(top) < ROWS)
    else $error("scroll offset out of range");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_out |-> !out_valid || rsp.ready)
    else $error("result register overwritten before it was taken");

  a_idle_progress: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && q_rd.valid && !out_valid |-> q_pop)
    else $error("queued item not taken while back end is free");
`endif

endmodule

// ----- hdl/text_console_writer_core.sv -----
// Top level of the text console writer: color register, front end, queue, back end.
//
//  Channel  Dir   Handshake            Payload
//  cmd      in    valid/ready          kind, char_code, cell_col, cell_row
//  rsp      out   valid/ready          cursor_col, cursor_row, cursor_linear,
//                                      read_char, read_attr
//  cfg      in    cfg_wr_en            cfg_wr_data -> text_color
//
//  Reads go through a registered memory read and the S_READ_WAIT state; other items do not.
//  A scroll blanks the new bottom row in the S_BLANK state through the single write port.
//  After reset a clearing pass writes every cell,
//  with cmd.ready low; configuration writes are taken during it.
//  A two-entry queue lets cmd keep accepting while rsp stalls or a scroll or read runs.
`timescale 1ns / 1ps

module text_console_writer_core import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  tcw_in_if.sink            cmd,
  tcw_out_if.source         rsp,
  input  logic              cfg_wr_en,
  input  logic [ATTR_W-1:0] cfg_wr_data
);

  logic [ATTR_W-1:0] text_color;
  q_wr_t             q_wr;
  q_rd_t             q_rd;
  logic              q_full;
  logic              q_pop;
  logic              busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= COLOR_RESET;
    end else if (cfg_wr_en) begin
      text_color <= cfg_wr_data;
    end
  end

  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .cmd    (cmd),
    .busy   (busy),
    .q_full (q_full),
    .q_wr   (q_wr)
  );

  tcw_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .q_wr (q_wr),
    .pop  (q_pop),
    .full (q_full),
    .q_rd (q_rd)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .text_color (text_color),
    .q_rd       (q_rd),
    .q_pop      (q_pop),
    .busy       (busy),
    .rsp        (rsp)
  );

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for text_console_writer_core: put, cursor, read and scroll behavior.
`timescale 1ns / 1ps

module tb_top;
  import tcw_pkg::*;

  localparam int SCREEN_COLS = COLUMNS_DEF;
  localparam int SCREEN_ROWS = ROWS_DEF;
  localparam int SETTLE_CYCLES = SCREEN_COLS + 16;  // scroll blanking plus margin
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [CUR_COL_W-1:0] col;
    logic [CUR_ROW_W-1:0] row;
    logic [CUR_LIN_W-1:0] lin;
    logic [CHAR_W-1:0]    rch;
    logic [ATTR_W-1:0]    rattr;
  } cursor_report_t;

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic [ATTR_W-1:0] cfg_wr_data;

  tcw_in_if  cmd_ch ();
  tcw_out_if rsp_ch ();

  text_console_writer_core uut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .rsp(rsp_ch),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Console shadow state
  logic [CELL_W-1:0] screen [0:SCREEN_COLS*SCREEN_ROWS-1];
  int unsigned       cur_col;
  int unsigned       cur_row;
  logic [ATTR_W-1:0] text_color;

  cursor_report_t pending_reports[$];
  int unsigned    mismatches;
  int unsigned    cycle_count;
  bit             quiet_mode;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void wipe_console();
    for (int i = 0; i < SCREEN_COLS * SCREEN_ROWS; i++) screen[i] = CELL_RESET;
    cur_col = 0;
    cur_row = 0;
    text_color = COLOR_RESET;
  endfunction

  function automatic logic [CELL_W-1:0] glyph_cell(input logic [CHAR_W-1:0] c);
    logic [ATTR_W-1:0] attr;
    attr = text_color | (text_color << 4);
    return {attr, c};
  endfunction

  function automatic void scroll_screen();
    for (int i = 0; i < (SCREEN_ROWS - 1) * SCREEN_COLS; i++) screen[i] = screen[i + SCREEN_COLS];
    for (int x = 0; x < SCREEN_COLS; x++)
      screen[(SCREEN_ROWS - 1) * SCREEN_COLS + x] = glyph_cell(CH_SPACE);
  endfunction

  function automatic void line_feed();
    cur_col = 0;
    if (cur_row + 1 >= SCREEN_ROWS) scroll_screen();
    else cur_row++;
  endfunction

  function automatic void put_glyph(input logic [CHAR_W-1:0] c);
    if (c == CH_BACKSPACE) begin
      if (cur_col > 0) cur_col--;  // saturates at column 0
      screen[cur_row * SCREEN_COLS + cur_col] = glyph_cell(CH_SPACE);
    end else if (c == CH_NEWLINE) begin
      line_feed();
    end else begin
      screen[cur_row * SCREEN_COLS + cur_col] = glyph_cell(c);
      if (cur_col + 1 >= SCREEN_COLS) line_feed();
      else cur_col++;
    end
  endfunction

  function automatic cursor_report_t advance_console(input logic [KIND_W-1:0] k,
                                                     input logic [CHAR_W-1:0] c,
                                                     input logic [CELL_COL_W-1:0] x,
                                                     input logic [CELL_ROW_W-1:0] y);
    cursor_report_t r;
    logic [CELL_W-1:0] scr_word;
    r = '0;
    case (k)
      KIND_PUT: put_glyph(c);
      KIND_SET: begin
        cur_col = (x < SCREEN_COLS) ? x : SCREEN_COLS - 1;
        cur_row = (y < SCREEN_ROWS) ? y : SCREEN_ROWS - 1;
      end
      KIND_READ: begin
        if (x < SCREEN_COLS && y < SCREEN_ROWS) begin
          scr_word = screen[y * SCREEN_COLS + x];
          r.rch = scr_word[CHAR_W-1:0];
          r.rattr = scr_word[CELL_W-1:CHAR_W];
        end
      end
      default: ;
    endcase
    r.col = CUR_COL_W'(cur_col);
    r.row = CUR_ROW_W'(cur_row);
    r.lin = CUR_LIN_W'(cur_row * SCREEN_COLS + cur_col);
    return r;
  endfunction

  task automatic log_mismatch(input string what, input int unsigned want, input int unsigned got);
    $display("mismatch at cycle %0d: %s expected %0h got %0h", cycle_count, what, want, got);
    mismatches++;
  endtask

  // Shadow update and result check, all on the same clock edge in a fixed order
  always @(posedge clk) begin
    cursor_report_t want;
    if (rst) begin
      wipe_console();
    end else begin
      if (cfg_wr_en) text_color = cfg_wr_data;
      if (cmd_ch.valid && cmd_ch.ready)
        pending_reports.push_back(advance_console(cmd_ch.kind, cmd_ch.char_code,
                                                  cmd_ch.cell_col, cmd_ch.cell_row));
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_reports.size() == 0) begin
          log_mismatch("unexpected item, cursor_linear", 0, 32'(rsp_ch.cursor_linear));
        end else begin
          want = pending_reports.pop_front();
          if (rsp_ch.cursor_col !== want.col)
            log_mismatch("cursor_col", 32'(want.col), 32'(rsp_ch.cursor_col));
          if (rsp_ch.cursor_row !== want.row)
            log_mismatch("cursor_row", 32'(want.row), 32'(rsp_ch.cursor_row));
          if (rsp_ch.cursor_linear !== want.lin)
            log_mismatch("cursor_linear", 32'(want.lin), 32'(rsp_ch.cursor_linear));
          if (rsp_ch.read_char !== want.rch)
            log_mismatch("read_char", 32'(want.rch), 32'(rsp_ch.read_char));
          if (rsp_ch.read_attr !== want.rattr)
            log_mismatch("read_attr", 32'(want.rattr), 32'(rsp_ch.read_attr));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("text_console_writer_core regression: fail");
      $finish;
    end
  end

  // Result side back-pressure
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet_mode && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
    end
  end

  task automatic send_item(input logic [KIND_W-1:0] k, input logic [CHAR_W-1:0] c,
                           input logic [CELL_COL_W-1:0] x, input logic [CELL_ROW_W-1:0] y);
    if (!quiet_mode && $urandom_range(0, 4) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.kind      <= k;
    cmd_ch.char_code <= c;
    cmd_ch.cell_col  <= x;
    cmd_ch.cell_row  <= y;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  // Drop valid, wait for all outstanding items, then let any scroll blanking finish
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_text_color(input logic [ATTR_W-1:0] c);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= c;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_random_item();
    logic [KIND_W-1:0]     k;
    logic [CHAR_W-1:0]     c;
    logic [CELL_COL_W-1:0] x;
    logic [CELL_ROW_W-1:0] y;
    int unsigned           pick;
    pick = $urandom_range(0, 99);
    c = CHAR_W'($urandom_range(0, 255));
    x = CELL_COL_W'($urandom_range(0, 127));
    y = CELL_ROW_W'($urandom_range(0, 31));
    if (pick < 60) begin
      k = KIND_PUT;
      pick = $urandom_range(0, 99);
      if (pick < 6) c = CH_BACKSPACE;
      else if (pick < 12) c = CH_NEWLINE;
      else if (pick >= 25) c = CHAR_W'($urandom_range(8'h20, 8'h7E));
    end else if (pick < 72) begin
      k = KIND_SET;
      if ($urandom_range(0, 9) != 0) x = CELL_COL_W'($urandom_range(0, SCREEN_COLS - 1));
      pick = $urandom_range(0, 99);
      // lean toward the bottom rows so scrolling happens often
      if (pick < 50) y = CELL_ROW_W'($urandom_range(SCREEN_ROWS - 5, SCREEN_ROWS - 1));
      else if (pick < 90) y = CELL_ROW_W'($urandom_range(0, SCREEN_ROWS - 1));
    end else if (pick < 94) begin
      k = KIND_READ;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // around the cursor, where text has just been written
        x = CELL_COL_W'($urandom_range(0, SCREEN_COLS - 1));
        y = CELL_ROW_W'((cur_row > 0 && $urandom_range(0, 1)) ? cur_row - 1 : cur_row);
      end else if (pick < 90) begin
        x = CELL_COL_W'($urandom_range(0, SCREEN_COLS - 1));
        y = CELL_ROW_W'($urandom_range(0, SCREEN_ROWS - 1));
      end
    end else begin
      k = KIND_UNUSED;
    end
    send_item(k, c, x, y);
  endtask

  task automatic test_reset_state();
    send_item(KIND_READ, 8'h00, 7'd0, 5'd0);
    send_item(KIND_READ, 8'h00, CELL_COL_W'(SCREEN_COLS - 1), CELL_ROW_W'(SCREEN_ROWS - 1));
  endtask

  task automatic test_put_and_erase();
    send_item(KIND_PUT, 8'h41, 7'd0, 5'd0);
    send_item(KIND_PUT, 8'hFF, 7'd127, 5'd31);
    send_item(KIND_PUT, 8'h00, 7'd0, 5'd0);
    repeat (3) send_item(KIND_PUT, CH_BACKSPACE, 7'd0, 5'd0);
    send_item(KIND_PUT, CH_BACKSPACE, 7'd0, 5'd0);  // already at column 0
    send_item(KIND_READ, 8'h00, 7'd0, 5'd0);
  endtask

  task automatic test_cursor_set();
    send_item(KIND_SET, 8'h00, 7'd127, 5'd31);
    send_item(KIND_SET, 8'h00, CELL_COL_W'(SCREEN_COLS), CELL_ROW_W'(SCREEN_ROWS));
    send_item(KIND_SET, 8'h00, 7'd0, 5'd0);
  endtask

  task automatic test_wrap_and_scroll();
    send_item(KIND_SET, 8'h00, CELL_COL_W'(SCREEN_COLS - 2), CELL_ROW_W'(SCREEN_ROWS - 1));
    send_item(KIND_PUT, 8'h78, 7'd0, 5'd0);
    send_item(KIND_PUT, 8'h79, 7'd0, 5'd0);       // last column: wraps and scrolls
    send_item(KIND_PUT, CH_NEWLINE, 7'd0, 5'd0);  // bottom row: scrolls again
    send_item(KIND_READ, 8'h00, CELL_COL_W'(SCREEN_COLS - 2), CELL_ROW_W'(SCREEN_ROWS - 3));
    send_item(KIND_READ, 8'h00, 7'd0, CELL_ROW_W'(SCREEN_ROWS - 1));
  endtask

  task automatic test_read_bounds();
    send_item(KIND_READ, 8'h00, CELL_COL_W'(SCREEN_COLS), 5'd0);
    send_item(KIND_READ, 8'h00, 7'd0, CELL_ROW_W'(SCREEN_ROWS));
    send_item(KIND_READ, 8'h00, 7'd127, 5'd31);
  endtask

  task automatic test_unused_kind();
    send_item(KIND_UNUSED, 8'hFF, 7'd127, 5'd31);
  endtask

  task automatic test_random_text(input logic [ATTR_W-1:0] c, input int unsigned n);
    set_text_color(c);
    repeat (n) send_random_item();
  endtask

  task automatic test_steady_flow(input int unsigned n);
    set_text_color(ATTR_W'($urandom_range(0, 255)));
    quiet_mode = 1'b1;
    repeat (n) send_random_item();
  endtask

  task automatic finish_run();
    settle();
    if (mismatches == 0) $display("text_console_writer_core regression: pass");
    else $display("text_console_writer_core regression: fail");
    $finish;
  endtask

  initial begin
    quiet_mode = 1'b0;
    mismatches = 0;
    cycle_count = 0;
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    cmd_ch.valid <= 1'b0;
    cmd_ch.kind <= KIND_PUT;
    cmd_ch.char_code <= '0;
    cmd_ch.cell_col <= '0;
    cmd_ch.cell_row <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_put_and_erase();
    test_cursor_set();
    test_wrap_and_scroll();
    test_read_bounds();
    test_unused_kind();
    test_random_text(8'h00, 70);
    test_random_text(8'hFF, 70);
    test_random_text(8'h3C, 70);
    test_random_text(ATTR_W'($urandom_range(0, 255)), 70);
    test_random_text(ATTR_W'($urandom_range(0, 255)), 70);
    test_steady_flow(50);
    finish_run();
  end

endmodule
